// ----- rtl/cbr_pkg.sv -----
// Shared types and constants for the comb bank reverb core.
// No dependencies; used by every module of the block except cbr_ram.
package cbr_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int CFG_W            = 16;
  localparam int LINE_COUNT       = 4;
  localparam int LINE_W           = 2;
  localparam int CFG_IDX_W        = 2;
  // Compare width for position + 1 against a clamped line length (lengths up to 65536)
  localparam int CMP_W            = CFG_W + 2;
  localparam int MAX_LINE_LEN_DEF = 32768;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LINE0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LINE1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LINE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LINE3 = 2'd3;

  // Line lengths after reset (250, 350, 430 and 600 ms at 48 kHz)
  localparam logic [CFG_W-1:0] RST_LENGTH_LINE0 = 16'd12000;
  localparam logic [CFG_W-1:0] RST_LENGTH_LINE1 = 16'd16800;
  localparam logic [CFG_W-1:0] RST_LENGTH_LINE2 = 16'd20640;
  localparam logic [CFG_W-1:0] RST_LENGTH_LINE3 = 16'd28800;

  // Controller to datapath commands
  typedef struct packed {
    logic              clear_wr;   // write zero at the clear counter, advance it
    logic              load_in;    // capture the input sample, seed the accumulator
    logic              rd_en;      // read the current line's tap
    logic              wr_en;      // write back feedback, accumulate, advance position
    logic              out_load;   // move the accumulator into the output register
    logic [LINE_W-1:0] line;       // line being visited
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clear counter sits on the last word
    logic out_free;    // output register can take a new result
  } status_t;

endpackage

// ----- rtl/cbr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module cbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cbr_ctrl.sv -----
// Sequencer for the comb bank reverb: clear pass, then read and write of each line per sample.
// Depends on cbr_pkg for the command and status types.
module cbr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  cbr_pkg::status_t status,
  output cbr_pkg::cmd_t    cmd
);

  import cbr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  // Next state and line counter
  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    unique case (state_r)
      S_CLEAR: begin
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        line_nxt = '0;
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (line_r == LINE_W'(LINE_COUNT - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          line_nxt  = line_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Hold state and line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      line_r  <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
    end
  end

  // Decode commands from state
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    cmd.clear_wr = (state_r == S_CLEAR);
    cmd.load_in  = (state_r == S_IDLE) && in_tvalid;
    cmd.rd_en    = (state_r == S_READ);
    cmd.wr_en    = (state_r == S_WRITE);
    cmd.out_load = (state_r == S_FINISH) && status.out_free;
    cmd.line     = line_r;
  end

endmodule

// ----- rtl/cbr_datapath.sv -----
// Datapath of the comb bank reverb: length registers, line positions, delay RAM,
// feedback and saturating accumulator, output register. Depends on cbr_pkg and cbr_ram.
module cbr_datapath #(
  parameter int MAX_LINE_LEN = cbr_pkg::MAX_LINE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbr_pkg::cmd_t                 cmd,
  output cbr_pkg::status_t              status,
  input  logic [cbr_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          cfg_we,
  input  logic [cbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbr_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbr_pkg::SAMPLE_W-1:0]  out_sample
);

  import cbr_pkg::*;

  localparam int DEPTH  = LINE_COUNT * MAX_LINE_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(MAX_LINE_LEN);

  logic [CFG_W-1:0]    len_r [LINE_COUNT];
  logic [POS_W-1:0]    pos_r [LINE_COUNT];
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] acc_r, acc_nxt;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_valid_r;

  logic [CFG_W-1:0]    cur_len;
  logic [POS_W-1:0]    cur_pos;
  logic [CMP_W-1:0]    eff_len;
  logic [CMP_W-1:0]    pos_plus;
  logic [POS_W-1:0]    pos_adv;
  logic [ADDR_W-1:0]   tap_addr;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_we;
  logic [SAMPLE_W-1:0] delayed;
  logic [SAMPLE_W-1:0] feedback;
  logic [SAMPLE_W:0]   sum;
  logic [SAMPLE_W-1:0] sum_sat;

  // Select the visited line and clamp its length to 1..MAX_LINE_LEN
  always_comb begin
    cur_len = len_r[cmd.line];
    cur_pos = pos_r[cmd.line];
    if (cur_len == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(cur_len) > CMP_W'(MAX_LINE_LEN)) begin
      eff_len = CMP_W'(MAX_LINE_LEN);
    end else begin
      eff_len = CMP_W'(cur_len);
    end
    pos_plus = CMP_W'(cur_pos) + CMP_W'(1);
    pos_adv  = (pos_plus >= eff_len) ? '0 : pos_plus[POS_W-1:0];
    tap_addr = ADDR_W'(cmd.line) * ADDR_W'(MAX_LINE_LEN) + ADDR_W'(cur_pos);
  end

  // Feedback write value and saturating tap sum
  always_comb begin
    feedback = sample_r + {delayed[SAMPLE_W-1], delayed[SAMPLE_W-1:1]};
    sum      = {acc_r[SAMPLE_W-1], acc_r}
             + {{3{delayed[SAMPLE_W-1]}}, delayed[SAMPLE_W-1:2]};
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sum_sat = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
    if (cmd.load_in) begin
      acc_nxt = in_sample;
    end else if (cmd.wr_en) begin
      acc_nxt = sum_sat;
    end else begin
      acc_nxt = acc_r;
    end
  end

  // RAM write port: clear pass or feedback write
  always_comb begin
    ram_we    = cmd.clear_wr || cmd.wr_en;
    ram_waddr = cmd.clear_wr ? clr_cnt_r : tap_addr;
    ram_wdata = cmd.clear_wr ? '0 : feedback;
  end

  cbr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (tap_addr),
    .rdata (delayed)
  );

  // Control registers: lengths, positions, clear counter, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0]    <= RST_LENGTH_LINE0;
      len_r[1]    <= RST_LENGTH_LINE1;
      len_r[2]    <= RST_LENGTH_LINE2;
      len_r[3]    <= RST_LENGTH_LINE3;
      for (int i = 0; i < LINE_COUNT; i++) begin
        pos_r[i] <= '0;
      end
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LENGTH_LINE0: len_r[0] <= cfg_wdata;
          REG_LENGTH_LINE1: len_r[1] <= cfg_wdata;
          REG_LENGTH_LINE2: len_r[2] <= cfg_wdata;
          REG_LENGTH_LINE3: len_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.wr_en) begin
        pos_r[cmd.line] <= pos_adv;
      end
      if (cmd.clear_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= in_sample;
    end
    acc_r <= acc_nxt;
    if (cmd.out_load) begin
      out_data_r <= acc_r;
    end
  end

  always_comb begin
    status.clear_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));
    status.out_free   = !out_valid_r || out_ready;
    out_valid         = out_valid_r;
    out_sample        = out_data_r;
  end

endmodule

// ----- rtl/comb_bank_reverb_core.sv -----
// Comb bank reverb core: four feedback comb lines in one delay RAM, summed onto the dry sample.
// One sample at a time: accept, read and write per line on the single RAM, then output load;
// the next sample waits longer while a stalled result still sits in the output register.
// Reset: synchronous, active low; then a clear pass over all 4*MAX_LINE_LEN words
// (131072 by default) zeroes the delay RAM with in_tready low.
// Configuration writes are taken meanwhile.
module comb_bank_reverb_core #(
  parameter int MAX_LINE_LEN = cbr_pkg::MAX_LINE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cbr_pkg::SAMPLE_W-1:0]  in_tdata,   // [31:0] sample_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cbr_pkg::SAMPLE_W-1:0]  out_tdata,  // [31:0] sample_out
  input  logic                          cfg_we,
  input  logic [cbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbr_pkg::CFG_W-1:0]     cfg_wdata
);

  import cbr_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cbr_datapath #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata)
  );

endmodule

// ----- rtl/cbr_checker.sv -----
// Port-level checks for the comb bank reverb core, bound to the top level.
// Depends on cbr_pkg for port widths.
module cbr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [cbr_pkg::SAMPLE_W-1:0]  out_tdata
);

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Delay RAM clear keeps input closed right after reset
  assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input open during reset clear");

  // No stale result appears after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // One sample at a time: input stays closed while the lines are processed
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready ##1 !in_tready
      ##1 !in_tready ##1 !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input accepted while a sample is in work");

endmodule

bind comb_bank_reverb_core cbr_checker u_cbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/comb_bank_reverb_core_tb.sv -----
// Self-checking testbench for comb_bank_reverb_core: directed table, then random phases.
// Depends on rtl/cbr_pkg.sv and rtl/comb_bank_reverb_core.sv; checks against its own predictor.
module comb_bank_reverb_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbr_pkg::*;

  localparam int          LINE_DEPTH  = MAX_LINE_LEN_DEF;
  localparam int          CYCLE_LIMIT = 700000;
  localparam int          MAX_WAIT    = 12;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 100;
  localparam int          DIR_ROWS    = 22;
  localparam logic [CFG_IDX_W-1:0] LEN_REG [LINE_COUNT] =
    '{REG_LENGTH_LINE0, REG_LENGTH_LINE1, REG_LENGTH_LINE2, REG_LENGTH_LINE3};

  typedef enum logic {ROW_SAMPLE, ROW_LENGTHS} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [SAMPLE_W-1:0]         sample;
    bit                          checked;   // want holds the typed-in result
    logic [SAMPLE_W-1:0]         want;
    logic [LINE_COUNT-1:0][CFG_W-1:0] lens; // line 0 in the lowest slice
  } dir_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata   = '0;   // [31:0] sample_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;         // [31:0] sample_out
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // Predictor state: delay memory, tap positions, programmed lengths
  bit   [SAMPLE_W-1:0]  delay_mem [LINE_COUNT][LINE_DEPTH];
  int unsigned          line_pos  [LINE_COUNT];
  logic [CFG_W-1:0]     line_len  [LINE_COUNT] =
    '{RST_LENGTH_LINE0, RST_LENGTH_LINE1, RST_LENGTH_LINE2, RST_LENGTH_LINE3};

  logic [SAMPLE_W-1:0]  reverb_expected [$];
  int                   error_count  = 0;
  int                   report_count = 0;
  int                   cycle_count  = 0;
  int                   next_gap     = 0;
  bit                   valid_held   = 1'b0;
  bit                   quiet_in     = 1'b0;
  bit                   quiet_out    = 1'b0;

  dir_row_t dir_table [DIR_ROWS] = '{
    // fresh memory, reset lengths: every tap reads zero, so the dry sample passes
    '{ROW_SAMPLE,  32'h0000_0000, 1'b1, 32'h0000_0000, '0},
    '{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, '0},
    '{ROW_SAMPLE,  32'h8000_0000, 1'b1, 32'h8000_0000, '0},
    '{ROW_SAMPLE,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, '0},
    '{ROW_SAMPLE,  32'h0000_0001, 1'b1, 32'h0000_0001, '0},
    '{ROW_SAMPLE,  32'h5555_5555, 1'b1, 32'h5555_5555, '0},
    '{ROW_SAMPLE,  32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, '0},
    // zero length, one-sample line, oversize and full length; lines shrink under a live position
    '{ROW_LENGTHS, '0, 1'b0, '0, {16'd32768, 16'hFFFF, 16'd1, 16'd0}},
    '{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h8000_0000, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h8000_0000, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h8000_0000, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h8000_0000, 1'b0, '0, '0},
    '{ROW_LENGTHS, '0, 1'b0, '0, {16'd32767, 16'd4, 16'd3, 16'd2}},
    '{ROW_SAMPLE,  32'h1234_5678, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'hEDCB_A988, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h8000_0000, 1'b0, '0, '0},
    '{ROW_SAMPLE,  32'h0000_0000, 1'b0, '0, '0}
  };

  comb_bank_reverb_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run one sample through the four comb lines and return the saturated mix
  function automatic logic [SAMPLE_W-1:0] reverb_next(input logic [SAMPLE_W-1:0] dry);
    longint                     mix;
    logic [SAMPLE_W-1:0]        tap;
    logic signed [SAMPLE_W-1:0] tap_half;
    logic signed [SAMPLE_W-1:0] tap_quarter;
    int unsigned                eff_len;
    int unsigned                pos;
    int                         ln;
    mix = longint'($signed(dry));
    for (ln = 0; ln < LINE_COUNT; ln++) begin
      if (line_len[ln] == '0) begin
        eff_len = 1;
      end else if (int'(line_len[ln]) > LINE_DEPTH) begin
        eff_len = LINE_DEPTH;
      end else begin
        eff_len = 32'(line_len[ln]);
      end
      pos         = line_pos[ln];
      tap         = delay_mem[ln][pos];
      tap_half    = $signed(tap) >>> 1;
      tap_quarter = $signed(tap) >>> 2;
      delay_mem[ln][pos] = dry + tap_half;
      pos++;
      if (pos >= eff_len) pos = 0;
      line_pos[ln] = pos;
      mix += longint'(tap_quarter);
      if (mix > longint'(32'sh7FFF_FFFF)) mix = longint'(32'sh7FFF_FFFF);
      if (mix < -longint'(64'h8000_0000)) mix = -longint'(64'h8000_0000);
    end
    return mix[SAMPLE_W-1:0];
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Offer one sample, hold it until taken, queue its expected result
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit checked,
                             input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] predicted;
    repeat (next_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    predicted = reverb_next(s);
    reverb_expected.push_back(checked ? want : predicted);
    next_gap = draw_wait(quiet_in);
    if (next_gap != 0) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
    end else begin
      valid_held = 1'b1;
    end
  endtask

  // Drop valid and wait until every queued result has drained
  task automatic drain_stream();
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    next_gap = 0;
    while (reverb_expected.size() != 0) @(posedge clk);
  endtask

  // Write all four length registers back to back, block idle
  task automatic program_lengths(input logic [LINE_COUNT-1:0][CFG_W-1:0] lens);
    int ln;
    for (ln = 0; ln < LINE_COUNT; ln++) begin
      cfg_we    <= 1'b1;
      cfg_index <= LEN_REG[ln];
      cfg_wdata <= lens[ln];
      @(posedge clk);
      line_len[ln] = lens[ln];
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall before each transaction
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(quiet_out);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reverb_expected.size() == 0) begin
        error_count++;
        report_count++;
        if (report_count <= 10)
          $display("unexpected result: sample_out=%h", out_tdata);
      end else begin
        want = reverb_expected.pop_front();
        if (out_tdata !== want) begin
          error_count++;
          report_count++;
          if (report_count <= 10)
            $display("sample_out mismatch: expected %h actual %h", want, out_tdata);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LINE_COUNT-1:0][CFG_W-1:0] lens;
    logic [SAMPLE_W-1:0]              s;
    int                               row;
    int                               phase;
    int                               item;
    int                               ln;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_table[row].kind == ROW_LENGTHS) begin
        drain_stream();
        program_lengths(dir_table[row].lens);
      end else begin
        send_sample(dir_table[row].sample, dir_table[row].checked, dir_table[row].want);
      end
    end

    // Random phases: new lengths each time, mostly short lines so taps recirculate
    for (phase = 0; phase < PHASES; phase++) begin
      drain_stream();
      for (ln = 0; ln < LINE_COUNT; ln++) begin
        case ($urandom_range(0, 9))
          0:       lens[ln] = '0;
          1:       lens[ln] = '1;
          2:       lens[ln] = CFG_W'(LINE_DEPTH);
          3:       lens[ln] = CFG_W'($urandom_range(0, 65535));
          default: lens[ln] = CFG_W'($urandom_range(1, 40));
        endcase
      end
      program_lengths(lens);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      for (item = 0; item < PHASE_ITEMS; item++) begin
        case ($urandom_range(0, 9))
          4:       s = SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
          5:       s = 32'h7FFF_FFFF - SAMPLE_W'($urandom_range(0, 255));
          6:       s = 32'h8000_0000 + SAMPLE_W'($urandom_range(0, 255));
          7:       s = {SAMPLE_W{$urandom_range(0, 1) == 1}};
          default: s = $urandom;
        endcase
        send_sample(s, 1'b0, '0);
      end
    end

    drain_stream();
    repeat (20) @(posedge clk);
    if (error_count == 0 && reverb_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
